>>> src/xxt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxt_pkg
// Shared types and constants of the XON/XOFF escaping transmitter.
// ----------------------------------------------------------------------------
package xxt_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W      = ADDR_W + 1;
    localparam int OP_W       = 3;
    localparam int BYTE_W     = 8;
    localparam int LEVEL_W    = 9;

    localparam logic [OP_W-1:0] OP_ENQUEUE   = 3'd0;
    localparam logic [OP_W-1:0] OP_TX_READY  = 3'd1;
    localparam logic [OP_W-1:0] OP_REQ_XOFF  = 3'd2;
    localparam logic [OP_W-1:0] OP_REQ_XON   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEER_XOFF = 3'd4;
    localparam logic [OP_W-1:0] OP_PEER_XON  = 3'd5;

    localparam logic [BYTE_W-1:0] CHAR_XOFF = 8'd19;
    localparam logic [BYTE_W-1:0] CHAR_XON  = 8'd17;
    localparam logic [BYTE_W-1:0] CHAR_ESC  = 8'd0;

    typedef struct packed {
        logic apply;
        logic read;
        logic send;
    } xxt_cmd_t;

    typedef struct packed {
        logic slot_free;
    } xxt_status_t;

endpackage

>>> src/xxt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xxt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/xxt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxt_ctrl
// Sequencer: take a transaction, read the FIFO head, then make the send.
// ----------------------------------------------------------------------------
module xxt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  xxt_pkg::xxt_status_t status,
    output xxt_pkg::xxt_cmd_t    cmd
);
    import xxt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.apply = in_valid;
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (status.slot_free)
                begin
                    cmd.send   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_READ))
        else $error("accepted transaction not followed by head read");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.apply, cmd.read, cmd.send}))
        else $error("more than one datapath command at once");

endmodule

>>> src/xxt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxt_datapath
// FIFO storage, flow-control flags, send selection and result register.
// ----------------------------------------------------------------------------
module xxt_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  xxt_pkg::xxt_cmd_t          cmd,
    output xxt_pkg::xxt_status_t       status,
    input  logic [xxt_pkg::OP_W-1:0]   opcode,
    input  logic [xxt_pkg::BYTE_W-1:0] data_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       tx_valid,
    output logic [xxt_pkg::BYTE_W-1:0] tx_byte,
    output logic [xxt_pkg::LEVEL_W-1:0] fifo_level,
    output logic                       dropped,
    output logic                       xoff_in_force
);
    import xxt_pkg::*;

    logic [ADDR_W-1:0] head_reg,  head_next;
    logic [CNT_W-1:0]  fill_reg,  fill_next;
    logic              uart_free_reg, uart_free_next;
    logic              xoff_pend_reg, xoff_pend_next;
    logic              xon_pend_reg,  xon_pend_next;
    logic              xoff_sent_reg, xoff_sent_next;
    logic              esc_reg,       esc_next;
    logic              peer_pause_reg, peer_pause_next;
    logic              drop_evt_reg,  drop_evt_next;

    logic              out_valid_reg, out_valid_next;
    logic              tx_valid_reg;
    logic [BYTE_W-1:0] tx_byte_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic              dropped_reg;
    logic              xoff_force_reg;

    logic              full;
    logic              wr_en;
    logic [SUM_W-1:0]  wr_sum;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              send_ok;
    logic [BYTE_W-1:0] send_byte;
    logic              pop;
    logic [ADDR_W-1:0] head_inc;

    assign full   = (fill_reg == CNT_W'(FIFO_DEPTH));
    assign wr_en  = cmd.apply && (opcode == OP_ENQUEUE) && !full;
    assign wr_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign wr_addr = (wr_sum >= SUM_W'(FIFO_DEPTH)) ?
                     ADDR_W'(wr_sum - SUM_W'(FIFO_DEPTH)) : ADDR_W'(wr_sum);
    assign head_inc = (SUM_W'(head_reg) + SUM_W'(1) >= SUM_W'(FIFO_DEPTH)) ?
                      '0 : ADDR_W'(SUM_W'(head_reg) + SUM_W'(1));

    xxt_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (data_byte),
        .re    (cmd.read),
        .raddr (head_reg),
        .rdata (rd_data)
    );

    always_comb
    begin
        head_next       = head_reg;
        fill_next       = fill_reg;
        uart_free_next  = uart_free_reg;
        xoff_pend_next  = xoff_pend_reg;
        xon_pend_next   = xon_pend_reg;
        xoff_sent_next  = xoff_sent_reg;
        esc_next        = esc_reg;
        peer_pause_next = peer_pause_reg;
        drop_evt_next   = drop_evt_reg;
        send_ok         = 1'b0;
        send_byte       = '0;
        pop             = 1'b0;

        if (cmd.apply)
        begin
            drop_evt_next = 1'b0;
            unique case (opcode)
                OP_ENQUEUE:
                begin
                    if (full)
                    begin
                        drop_evt_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                OP_TX_READY:  uart_free_next = 1'b1;
                OP_REQ_XOFF:  xoff_pend_next = xoff_pend_reg | ~xoff_sent_reg;
                OP_REQ_XON:   xon_pend_next  = xon_pend_reg | xoff_sent_reg;
                OP_PEER_XOFF: peer_pause_next = 1'b1;
                OP_PEER_XON:  peer_pause_next = 1'b0;
                default:      ;
            endcase
        end

        if (cmd.send && uart_free_reg)
        begin
            priority if (esc_reg && (fill_reg != '0))
            begin
                send_ok   = 1'b1;
                send_byte = rd_data;
                esc_next  = 1'b0;
                pop       = 1'b1;
            end
            else if (xoff_pend_reg)
            begin
                send_ok        = 1'b1;
                send_byte      = CHAR_XOFF;
                xoff_sent_next = 1'b1;
                xoff_pend_next = 1'b0;
            end
            else if (xon_pend_reg)
            begin
                send_ok        = 1'b1;
                send_byte      = CHAR_XON;
                xoff_sent_next = 1'b0;
                xon_pend_next  = 1'b0;
            end
            else
            begin
                esc_next = 1'b0;
                if (!peer_pause_reg && (fill_reg != '0))
                begin
                    send_ok = 1'b1;
                    if ((rd_data == CHAR_ESC) || (rd_data == CHAR_XON) ||
                        (rd_data == CHAR_XOFF))
                    begin
                        send_byte = CHAR_ESC;
                        esc_next  = 1'b1;
                    end
                    else
                    begin
                        send_byte = rd_data;
                        pop       = 1'b1;
                    end
                end
            end
        end

        if (pop)
        begin
            head_next = head_inc;
            fill_next = fill_reg - CNT_W'(1);
        end
        if (send_ok)
        begin
            uart_free_next = 1'b0;
        end
    end

    assign status.slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.send)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            fill_reg       <= '0;
            uart_free_reg  <= 1'b1;
            xoff_pend_reg  <= 1'b0;
            xon_pend_reg   <= 1'b0;
            xoff_sent_reg  <= 1'b0;
            esc_reg        <= 1'b0;
            peer_pause_reg <= 1'b0;
            drop_evt_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            uart_free_reg  <= uart_free_next;
            xoff_pend_reg  <= xoff_pend_next;
            xon_pend_reg   <= xon_pend_next;
            xoff_sent_reg  <= xoff_sent_next;
            esc_reg        <= esc_next;
            peer_pause_reg <= peer_pause_next;
            drop_evt_reg   <= drop_evt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.send)
        begin
            tx_valid_reg   <= send_ok;
            tx_byte_reg    <= send_byte;
            level_reg      <= LEVEL_W'(fill_next);
            dropped_reg    <= drop_evt_reg;
            xoff_force_reg <= xoff_sent_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_valid      = tx_valid_reg;
    assign tx_byte       = tx_byte_reg;
    assign fifo_level    = level_reg;
    assign dropped       = dropped_reg;
    assign xoff_in_force = xoff_force_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(FIFO_DEPTH))
        else $error("fill count above FIFO depth");

    a_flow_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(xoff_pend_reg && xon_pend_reg))
        else $error("XOFF and XON pending together");

    a_escape_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> (fill_reg != '0))
        else $error("escape pair open with empty FIFO");

    a_send_busies_uart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.send && send_ok) |=> !uart_free_reg)
        else $error("transmitter still free after a byte was sent");

endmodule

>>> src/xon_xoff_escaping_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xon_xoff_escaping_transmitter
// UART transmit front end with XON/XOFF flow control and byte stuffing.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one event per transaction:
// opcode selects enqueue, transmitter ready, request XOFF/XON, or peer
// XOFF/XON; data_byte is the byte to enqueue. Output channel
// (out_valid/out_ready) returns one result per event: tx_valid/tx_byte for
// the byte handed to the UART, fifo_level, dropped and xoff_in_force.
// Sequence: an event is taken in the accept step, the FIFO head is read
// from the RAM in the read step, and the result is registered in the send
// step, which waits while the result register is still full; the read step
// is there for the registered read of the RAM, which follows the write.
// The next event is accepted the cycle after the result is loaded,
// even while that result still waits on out_ready.
// Reset empties the FIFO, marks the UART free and clears all flow flags.
// When the receiver stalls, the result register holds and the block waits
// in its send step until the register is taken.
// ----------------------------------------------------------------------------
module xon_xoff_escaping_transmitter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [xxt_pkg::OP_W-1:0]    opcode,
    input  logic [xxt_pkg::BYTE_W-1:0]  data_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        tx_valid,
    output logic [xxt_pkg::BYTE_W-1:0]  tx_byte,
    output logic [xxt_pkg::LEVEL_W-1:0] fifo_level,
    output logic                        dropped,
    output logic                        xoff_in_force
);
    import xxt_pkg::*;

    xxt_cmd_t    cmd;
    xxt_status_t status;

    xxt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    xxt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (opcode),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .fifo_level    (fifo_level),
        .dropped       (dropped),
        .xoff_in_force (xoff_in_force)
    );

endmodule
